/* rtl/frr_pkg.sv */
// shared types and constants for the fragment reassembly reorder core
package frr_pkg;

  localparam int unsigned SRC_W  = 3;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned LEN_W  = 12;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned KEY_W  = SRC_W + SEQ_W + OFF_W;
  localparam int unsigned INFO_W = LEN_W + 1 + TAG_W;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_PARK  = 2'd1,
    KIND_DUP   = 2'd2,
    KIND_FULL  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SRC_W-1:0]  src;
    logic [OFF_W-1:0]  off;
    logic [LEN_W-1:0]  len;
    logic [TAG_W-1:0]  tag;
    logic              done;
    logic [OFF_W-1:0]  size;
  } res_t;

  function automatic res_t make_write(logic [SRC_W-1:0] src, logic [OFF_W-1:0] off,
                                      logic [LEN_W-1:0] len, logic last,
                                      logic [TAG_W-1:0] tag);
    res_t r;
    r.kind = KIND_WRITE;
    r.src  = src;
    r.off  = off;
    r.len  = len;
    r.tag  = tag;
    r.done = last;
    r.size = last ? OFF_W'(off + OFF_W'(len)) : '0;
    return r;
  endfunction

  function automatic res_t make_note(kind_t kind, logic [SRC_W-1:0] src,
                                     logic [OFF_W-1:0] off, logic [LEN_W-1:0] len,
                                     logic [TAG_W-1:0] tag);
    res_t r;
    r.kind = kind;
    r.src  = src;
    r.off  = off;
    r.len  = len;
    r.tag  = tag;
    r.done = 1'b0;
    r.size = '0;
    return r;
  endfunction

endpackage

/* rtl/fragment_reassembly_reorder_core.sv */
// top level: per-source in-order fragment reassembly with a tagged out-of-order store
//
//  channel | ports                      | handshake
//  --------+----------------------------+-------------------------------------
//  input   | in_* fields                | start high while busy low
//  result  | out_* fields, out_run_end  | out_valid strobe, one cycle per beat
//
//  store scans: one for a parked or dropped beat, plus one per drained fragment,
//    plus a final scan that misses
//  the store scan reads one slot per cycle from the key/info memory port
//  a source_node of NODES or more is ignored and busy stays low
//  reset clears expectations and slot valid bits at once, no sweep
//  the receiver cannot stall; results leave one per cycle at most
module fragment_reassembly_reorder_core #(
  parameter int unsigned NODES = 8,
  parameter int unsigned SLOTS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [frr_pkg::SRC_W-1:0]   in_source_node,
  input  logic [frr_pkg::SEQ_W-1:0]   in_msg_seq,
  input  logic [frr_pkg::OFF_W-1:0]   in_frag_offset,
  input  logic [frr_pkg::LEN_W-1:0]   in_frag_len,
  input  logic                        in_last_frag,
  input  logic [frr_pkg::TAG_W-1:0]   in_payload_tag,
  output logic                        out_valid,
  output logic [1:0]                  out_kind,
  output logic [frr_pkg::SRC_W-1:0]   out_source,
  output logic [frr_pkg::OFF_W-1:0]   out_write_offset,
  output logic [frr_pkg::LEN_W-1:0]   out_write_len,
  output logic [frr_pkg::TAG_W-1:0]   out_tag,
  output logic                        out_message_done,
  output logic [frr_pkg::OFF_W-1:0]   out_message_size,
  output logic                        out_run_end
);

  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW = $clog2(SLOTS + 1);
  localparam int unsigned NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int unsigned EW = frr_pkg::SEQ_W + frr_pkg::OFF_W;

  typedef enum logic [2:0] {ST_IDLE, ST_EXP, ST_SCAN, ST_FIN} state_t;

  state_t                       state_r, state_nxt;
  logic [frr_pkg::SRC_W-1:0]    src_r, src_nxt;
  logic [frr_pkg::SEQ_W-1:0]    msg_r, msg_nxt;
  logic [frr_pkg::OFF_W-1:0]    off_r, off_nxt;
  logic [frr_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic                         last_r, last_nxt;
  logic [frr_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic [frr_pkg::SEQ_W-1:0]    em_r, em_nxt;
  logic [frr_pkg::OFF_W-1:0]    eo_r, eo_nxt;
  logic                         drain_r, drain_nxt;
  logic [CW-1:0]                iss_r, iss_nxt;
  logic                         rdp_r, rdp_nxt;
  logic [AW-1:0]                rdi_r, rdi_nxt;
  logic [SLOTS-1:0]             valid_r, valid_nxt;
  logic [NODES-1:0]             evld_r, evld_nxt;
  frr_pkg::res_t                pend_r, pend_nxt;
  logic                         pendv_r, pendv_nxt;
  frr_pkg::res_t                ores_r, ores_nxt;
  logic                         ov_r, ov_nxt;
  logic                         orun_r, orun_nxt;

  logic [frr_pkg::KEY_W-1:0]    key_mem  [SLOTS];
  logic [frr_pkg::INFO_W-1:0]   info_mem [SLOTS];
  logic [EW-1:0]                exp_mem  [NODES];
  logic [frr_pkg::KEY_W-1:0]    rd_key_r;
  logic [frr_pkg::INFO_W-1:0]   rd_info_r;
  logic [EW-1:0]                exp_rd_r;
  logic                         exp_rv_r;

  logic [AW-1:0]                rd_addr;
  logic                         park_we;
  logic [AW-1:0]                free_idx;
  logic                         free_any;
  logic                         emit_en;
  frr_pkg::res_t                emit_res;
  logic [frr_pkg::KEY_W-1:0]    target;
  logic                         hit;
  logic                         last_cmp;
  logic                         accept;
  logic [frr_pkg::LEN_W-1:0]    h_len;
  logic                         h_last;
  logic [frr_pkg::TAG_W-1:0]    h_tag;

  assign accept  = start && (state_r == ST_IDLE) && (32'(in_source_node) < NODES);
  assign rd_addr = (iss_r < CW'(SLOTS)) ? iss_r[AW-1:0] : '0;
  assign target  = drain_r ? {src_r, em_r, eo_r} : {src_r, msg_r, off_r};
  assign hit     = rdp_r && valid_r[rdi_r] && (rd_key_r == target);
  assign last_cmp = rdp_r && (rdi_r == AW'(SLOTS - 1));
  assign h_len   = rd_info_r[frr_pkg::INFO_W-1 -: frr_pkg::LEN_W];
  assign h_last  = rd_info_r[frr_pkg::TAG_W];
  assign h_tag   = rd_info_r[frr_pkg::TAG_W-1:0];

  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = AW'(i);
        free_any = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    msg_nxt   = msg_r;
    off_nxt   = off_r;
    len_nxt   = len_r;
    last_nxt  = last_r;
    tag_nxt   = tag_r;
    em_nxt    = em_r;
    eo_nxt    = eo_r;
    drain_nxt = drain_r;
    iss_nxt   = iss_r;
    rdp_nxt   = rdp_r;
    rdi_nxt   = rdi_r;
    valid_nxt = valid_r;
    evld_nxt  = evld_r;
    pend_nxt  = pend_r;
    pendv_nxt = pendv_r;
    ores_nxt  = ores_r;
    ov_nxt    = 1'b0;
    orun_nxt  = 1'b0;
    park_we   = 1'b0;
    emit_en   = 1'b0;
    emit_res  = pend_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          src_nxt   = in_source_node;
          msg_nxt   = in_msg_seq;
          off_nxt   = in_frag_offset;
          len_nxt   = in_frag_len;
          last_nxt  = in_last_frag;
          tag_nxt   = in_payload_tag;
          state_nxt = ST_EXP;
        end
      end
      ST_EXP: begin
        iss_nxt   = '0;
        rdp_nxt   = 1'b0;
        state_nxt = ST_SCAN;
        if (exp_rv_r && msg_r == exp_rd_r[EW-1 -: frr_pkg::SEQ_W] &&
            off_r == exp_rd_r[frr_pkg::OFF_W-1:0] ||
            !exp_rv_r && msg_r == '0 && off_r == '0) begin
          emit_en   = 1'b1;
          emit_res  = frr_pkg::make_write(src_r, off_r, len_r, last_r, tag_r);
          drain_nxt = 1'b1;
          if (last_r) begin
            em_nxt = msg_r + 1'b1;
            eo_nxt = '0;
          end else begin
            em_nxt = msg_r;
            eo_nxt = off_r + frr_pkg::OFF_W'(len_r);
          end
        end else begin
          drain_nxt = 1'b0;
          em_nxt    = exp_rv_r ? exp_rd_r[EW-1 -: frr_pkg::SEQ_W] : '0;
          eo_nxt    = exp_rv_r ? exp_rd_r[frr_pkg::OFF_W-1:0] : '0;
        end
      end
      ST_SCAN: begin
        if (iss_r < CW'(SLOTS)) begin
          iss_nxt = iss_r + 1'b1;
          rdp_nxt = 1'b1;
          rdi_nxt = iss_r[AW-1:0];
        end else begin
          rdp_nxt = 1'b0;
        end
        if (hit) begin
          iss_nxt   = '0;
          rdp_nxt   = 1'b0;
          drain_nxt = 1'b1;
          emit_en   = 1'b1;
          if (drain_r) begin
            valid_nxt[rdi_r] = 1'b0;
            emit_res = frr_pkg::make_write(src_r, eo_r, h_len, h_last, h_tag);
            if (h_last) begin
              em_nxt = em_r + 1'b1;
              eo_nxt = '0;
            end else begin
              eo_nxt = eo_r + frr_pkg::OFF_W'(h_len);
            end
          end else begin
            emit_res = frr_pkg::make_note(frr_pkg::KIND_DUP, src_r, off_r, len_r, tag_r);
          end
        end else if (last_cmp) begin
          if (drain_r) begin
            state_nxt = ST_FIN;
          end else begin
            iss_nxt   = '0;
            rdp_nxt   = 1'b0;
            drain_nxt = 1'b1;
            emit_en   = 1'b1;
            if (free_any) begin
              park_we = 1'b1;
              valid_nxt[free_idx] = 1'b1;
              emit_res = frr_pkg::make_note(frr_pkg::KIND_PARK, src_r, off_r, len_r, tag_r);
            end else begin
              emit_res = frr_pkg::make_note(frr_pkg::KIND_FULL, src_r, off_r, len_r, tag_r);
            end
          end
        end
      end
      ST_FIN: begin
        ov_nxt    = 1'b1;
        ores_nxt  = pend_r;
        orun_nxt  = 1'b1;
        pendv_nxt = 1'b0;
        evld_nxt[NW'(src_r)] = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (emit_en) begin
      if (pendv_r) begin
        ov_nxt   = 1'b1;
        ores_nxt = pend_r;
        orun_nxt = 1'b0;
      end
      pend_nxt  = emit_res;
      pendv_nxt = 1'b1;
    end
  end

  // slot store and per-source expectation memory
  always_ff @(posedge clk) begin
    if (park_we) begin
      key_mem[free_idx]  <= {src_r, msg_r, off_r};
      info_mem[free_idx] <= {len_r, last_r, tag_r};
    end
    rd_key_r  <= key_mem[rd_addr];
    rd_info_r <= info_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN) begin
      exp_mem[NW'(src_r)] <= {em_r, eo_r};
    end
    exp_rd_r <= exp_mem[NW'(in_source_node)];
    exp_rv_r <= evld_r[NW'(in_source_node)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= '0;
      evld_r  <= '0;
      pendv_r <= 1'b0;
      ov_r    <= 1'b0;
      orun_r  <= 1'b0;
      rdp_r   <= 1'b0;
      iss_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      evld_r  <= evld_nxt;
      pendv_r <= pendv_nxt;
      ov_r    <= ov_nxt;
      orun_r  <= orun_nxt;
      rdp_r   <= rdp_nxt;
      iss_r   <= iss_nxt;
      drain_r <= drain_nxt;
    end
    src_r  <= src_nxt;
    msg_r  <= msg_nxt;
    off_r  <= off_nxt;
    len_r  <= len_nxt;
    last_r <= last_nxt;
    tag_r  <= tag_nxt;
    em_r   <= em_nxt;
    eo_r   <= eo_nxt;
    rdi_r  <= rdi_nxt;
    pend_r <= pend_nxt;
    ores_r <= ores_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = ov_r;
  assign out_kind         = ores_r.kind;
  assign out_source       = ores_r.src;
  assign out_write_offset = ores_r.off;
  assign out_write_len    = ores_r.len;
  assign out_tag          = ores_r.tag;
  assign out_message_done = ores_r.done;
  assign out_message_size = ores_r.size;
  assign out_run_end      = orun_r;

endmodule

/* rtl/frr_checker.sv */
// port-level checker for the fragment reassembly reorder core, with its bind
module frr_checker #(
  parameter int unsigned NODES = 8
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic [frr_pkg::SRC_W-1:0]  in_source_node,
  input logic                       out_valid,
  input logic [1:0]                 out_kind,
  input logic                       out_message_done,
  input logic [frr_pkg::OFF_W-1:0]  out_message_size,
  input logic                       out_run_end
);

  a_done_only_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != frr_pkg::KIND_WRITE |-> !out_message_done)
    else $error("completion flagged on a non-write beat");

  a_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_message_done |-> out_message_size == '0)
    else $error("message size set without completion");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (32'(in_source_node) < NODES) |=> busy)
    else $error("accepted beat did not raise busy");

  a_run_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_end |=> !out_valid)
    else $error("result beat right after run end");

endmodule

bind fragment_reassembly_reorder_core frr_checker #(.NODES(NODES)) u_frr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_source_node   (in_source_node),
  .out_valid        (out_valid),
  .out_kind         (out_kind),
  .out_message_done (out_message_done),
  .out_message_size (out_message_size),
  .out_run_end      (out_run_end)
);
